// File: rtl/psmst_pkg.sv
// Package for the per-symbol market statistics table: codes, row layout and reset row.
package psmst_pkg;

    localparam int SYMBOLS_DEF = 4096;

    localparam int FUNC_W   = 3;
    localparam int LOCATE_W = 16;
    localparam int SIDE_W   = 8;
    localparam int PRICE_W  = 32;
    localparam int QTY_W    = 64;
    localparam int CNT_W    = 32;

    localparam logic [FUNC_W-1:0] FN_ADD      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CANCEL   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TRADE    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CROSS    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_NOP      = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SNAPSHOT = 3'd5;

    localparam logic [SIDE_W-1:0] SIDE_BUY  = 8'd66;
    localparam logic [SIDE_W-1:0] SIDE_SELL = 8'd83;

    localparam logic [PRICE_W-1:0] BID_NONE = '0;
    localparam logic [PRICE_W-1:0] ASK_NONE = '1;

    typedef struct packed {
        logic [CNT_W-1:0]   adds;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [QTY_W-1:0]   cancelled;
        logic [QTY_W-1:0]   notional;
        logic [QTY_W-1:0]   volume;
        logic [CNT_W-1:0]   trades;
        logic [QTY_W-1:0]   buy;
        logic [QTY_W-1:0]   sell;
    } t_row;

    localparam t_row ROW_RESET = '{
        adds:      '0,
        bid:       BID_NONE,
        ask:       ASK_NONE,
        cancelled: '0,
        notional:  '0,
        volume:    '0,
        trades:    '0,
        buy:       '0,
        sell:      '0
    };

endpackage

// File: rtl/per_symbol_market_stats_table.sv
// Per-symbol market statistics table: one row of sums and counters per symbol in a single RAM.
//
//   channel  | direction | handshake                      | payload
//   ---------+-----------+--------------------------------+---------------------------------
//   command  | in        | start high while busy is low   | i_func, i_locate, i_side,
//            |           |                                | i_price, i_shares
//   snapshot | out       | o_snap_valid, one cycle        | o_snap_symbol .. o_snap_ask
//
// An item moves through steps: the accept cycle issues the row read, the next forms the
// two price-by-quantity partial products, and the last adds and writes the row back.
// The registered RAM read and the split multiply set these steps. A snapshot is on the outputs
// in the cycle after write-back, when the next item may already be accepted.
// After reset a clearing pass writes every row once, with busy held high.
// The receiver cannot stall; a snapshot is on the outputs for exactly one cycle.
module per_symbol_market_stats_table #(
    parameter int SYMBOLS = psmst_pkg::SYMBOLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [psmst_pkg::FUNC_W-1:0]   i_func,
    input  logic [psmst_pkg::LOCATE_W-1:0] i_locate,
    input  logic [psmst_pkg::SIDE_W-1:0]   i_side,
    input  logic [psmst_pkg::PRICE_W-1:0]  i_price,
    input  logic [psmst_pkg::QTY_W-1:0]    i_shares,
    output logic                           o_snap_valid,
    output logic [psmst_pkg::LOCATE_W-1:0] o_snap_symbol,
    output logic [psmst_pkg::QTY_W-1:0]    o_snap_notional,
    output logic [psmst_pkg::QTY_W-1:0]    o_snap_volume,
    output logic [psmst_pkg::QTY_W-1:0]    o_snap_buy,
    output logic [psmst_pkg::QTY_W-1:0]    o_snap_sell,
    output logic [psmst_pkg::QTY_W-1:0]    o_snap_cancelled,
    output logic [psmst_pkg::CNT_W-1:0]    o_snap_trades,
    output logic [psmst_pkg::CNT_W-1:0]    o_snap_adds,
    output logic [psmst_pkg::PRICE_W-1:0]  o_snap_bid,
    output logic [psmst_pkg::PRICE_W-1:0]  o_snap_ask
);
    import psmst_pkg::*;

    localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam logic [AW-1:0] LAST_ROW = AW'(SYMBOLS - 1);
    localparam int HALF = QTY_W / 2;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_WB    = 2'd3;

    t_row r_mem [SYMBOLS];
    t_row r_rd;

    logic [1:0]          r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic                accept;
    logic                in_range;

    logic [FUNC_W-1:0]   r_func;
    logic [LOCATE_W-1:0] r_locate;
    logic [SIDE_W-1:0]   r_side;
    logic [PRICE_W-1:0]  r_price;
    logic [QTY_W-1:0]    r_shares;
    logic                r_hit;
    logic [QTY_W-1:0]    r_prod_lo;
    logic [HALF-1:0]     r_prod_hi;
    logic [QTY_W-1:0]    prod_lo_full;
    logic [HALF-1:0]     prod_hi_full;

    t_row                n_row;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_row                wr_data;

    logic                r_snap_valid;
    t_row                r_snap;
    logic [LOCATE_W-1:0] r_snap_symbol;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = ({1'b0, i_locate} < (LOCATE_W + 1)'(SYMBOLS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_addr == LAST_ROW) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_READ;
            ST_READ:  n_state = ST_WB;
            ST_WB:    n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Capture the item and read its row at the accept edge.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_locate <= i_locate;
            r_side   <= i_side;
            r_price  <= i_price;
            r_shares <= i_shares;
            r_hit    <= in_range;
            r_rd     <= r_mem[i_locate[AW-1:0]];
        end
    end

    // Only the low half of the upper partial product reaches the 64-bit sum.
    assign prod_lo_full = QTY_W'(r_price) * QTY_W'(r_shares[HALF-1:0]);
    assign prod_hi_full = HALF'(r_price * r_shares[QTY_W-1:HALF]);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_prod_lo <= prod_lo_full;
            r_prod_hi <= prod_hi_full;
        end
    end

    always_comb begin
        n_row = r_rd;
        case (r_func)
            FN_ADD: begin
                n_row.adds = r_rd.adds + 1'b1;
                if (r_side == SIDE_BUY) begin
                    if (r_price > r_rd.bid) n_row.bid = r_price;
                end else if (r_side == SIDE_SELL) begin
                    if (r_price < r_rd.ask) n_row.ask = r_price;
                end
            end
            FN_CANCEL: n_row.cancelled = r_rd.cancelled + r_shares;
            FN_TRADE, FN_CROSS: begin
                if (r_shares != '0) begin
                    n_row.notional = r_rd.notional + r_prod_lo + {r_prod_hi, {HALF{1'b0}}};
                    n_row.volume   = r_rd.volume + r_shares;
                    n_row.trades   = r_rd.trades + 1'b1;
                    if (r_func == FN_TRADE) begin
                        if (r_side == SIDE_BUY) begin
                            n_row.buy = r_rd.buy + r_shares;
                        end else if (r_side == SIDE_SELL) begin
                            n_row.sell = r_rd.sell + r_shares;
                        end
                    end
                end
            end
            FN_SNAPSHOT: begin
                n_row.bid = BID_NONE;
                n_row.ask = ASK_NONE;
            end
            default: n_row = r_rd;
        endcase
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = ROW_RESET;
        end else begin
            wr_en   = (r_state == ST_WB) && r_hit;
            wr_addr = r_locate[AW-1:0];
            wr_data = n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else begin
            r_snap_valid <= (r_state == ST_WB) && r_hit && (r_func == FN_SNAPSHOT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WB) begin
            r_snap        <= r_rd;
            r_snap_symbol <= r_locate;
        end
    end

    assign o_snap_valid     = r_snap_valid;
    assign o_snap_symbol    = r_snap_symbol;
    assign o_snap_notional  = r_snap.notional;
    assign o_snap_volume    = r_snap.volume;
    assign o_snap_buy       = r_snap.buy;
    assign o_snap_sell      = r_snap.sell;
    assign o_snap_cancelled = r_snap.cancelled;
    assign o_snap_trades    = r_snap.trades;
    assign o_snap_adds      = r_snap.adds;
    assign o_snap_bid       = r_snap.bid;
    assign o_snap_ask       = r_snap.ask;

endmodule

// File: sim/per_symbol_market_stats_table_tb.sv
// Self-checking testbench for the per-symbol market statistics table.
`timescale 1ns / 1ps

module per_symbol_market_stats_table_tb;

    import psmst_pkg::*;

    localparam int SYMBOLS    = SYMBOLS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 2000;
    localparam int SETTLE     = 20;

    // Func codes that the package leaves unnamed; the block treats them as no-ops.
    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [LOCATE_W-1:0] locate;
        logic [SIDE_W-1:0]   side;
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    shares;
    } t_msg;

    typedef struct packed {
        logic [CNT_W-1:0]   adds;
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [QTY_W-1:0]   cancelled;
        logic [QTY_W-1:0]   notional;
        logic [QTY_W-1:0]   volume;
        logic [CNT_W-1:0]   trades;
        logic [QTY_W-1:0]   buy;
        logic [QTY_W-1:0]   sell;
    } t_sym_stats;

    typedef struct packed {
        logic [LOCATE_W-1:0] symbol;
        logic [QTY_W-1:0]    notional;
        logic [QTY_W-1:0]    volume;
        logic [QTY_W-1:0]    buy;
        logic [QTY_W-1:0]    sell;
        logic [QTY_W-1:0]    cancelled;
        logic [CNT_W-1:0]    trades;
        logic [CNT_W-1:0]    adds;
        logic [PRICE_W-1:0]  bid;
        logic [PRICE_W-1:0]  ask;
    } t_snap;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   i_func;
    logic [LOCATE_W-1:0] i_locate;
    logic [SIDE_W-1:0]   i_side;
    logic [PRICE_W-1:0]  i_price;
    logic [QTY_W-1:0]    i_shares;
    logic                o_snap_valid;
    logic [LOCATE_W-1:0] o_snap_symbol;
    logic [QTY_W-1:0]    o_snap_notional;
    logic [QTY_W-1:0]    o_snap_volume;
    logic [QTY_W-1:0]    o_snap_buy;
    logic [QTY_W-1:0]    o_snap_sell;
    logic [QTY_W-1:0]    o_snap_cancelled;
    logic [CNT_W-1:0]    o_snap_trades;
    logic [CNT_W-1:0]    o_snap_adds;
    logic [PRICE_W-1:0]  o_snap_bid;
    logic [PRICE_W-1:0]  o_snap_ask;

    per_symbol_market_stats_table #(
        .SYMBOLS(SYMBOLS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_locate        (i_locate),
        .i_side          (i_side),
        .i_price         (i_price),
        .i_shares        (i_shares),
        .o_snap_valid    (o_snap_valid),
        .o_snap_symbol   (o_snap_symbol),
        .o_snap_notional (o_snap_notional),
        .o_snap_volume   (o_snap_volume),
        .o_snap_buy      (o_snap_buy),
        .o_snap_sell     (o_snap_sell),
        .o_snap_cancelled(o_snap_cancelled),
        .o_snap_trades   (o_snap_trades),
        .o_snap_adds     (o_snap_adds),
        .o_snap_bid      (o_snap_bid),
        .o_snap_ask      (o_snap_ask)
    );

    always #10 i_clk = ~i_clk;

    t_sym_stats stats_tbl [SYMBOLS];
    t_snap      expected_snaps [$];
    t_msg       pending_msgs [$];
    t_msg       cur_msg;

    logic [LOCATE_W-1:0] hot_locs [8];

    int n_total;
    int n_sent;
    int n_snaps_seen;
    int n_ignored;
    int n_errors;
    int gap_left;
    int calm_left;
    int idle_cycles;

    logic msg_accept;
    assign msg_accept = start && !busy;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Updates the shadow table for one accepted item and queues any snapshot it yields.
    function automatic void apply_message(t_msg m);
        t_snap snap;
        if (m.locate >= SYMBOLS) begin
            n_ignored++;
            return;
        end
        case (m.func)
            FN_ADD: begin
                stats_tbl[m.locate].adds += 1;
                if (m.side == SIDE_BUY) begin
                    if (m.price > stats_tbl[m.locate].bid) stats_tbl[m.locate].bid = m.price;
                end else if (m.side == SIDE_SELL) begin
                    if (m.price < stats_tbl[m.locate].ask) stats_tbl[m.locate].ask = m.price;
                end
            end
            FN_CANCEL: begin
                stats_tbl[m.locate].cancelled += m.shares;
            end
            FN_TRADE, FN_CROSS: begin
                if (m.shares != '0) begin
                    stats_tbl[m.locate].notional += {32'd0, m.price} * m.shares;
                    stats_tbl[m.locate].volume   += m.shares;
                    stats_tbl[m.locate].trades   += 1;
                    // Cross trades carry no side volume.
                    if (m.func == FN_TRADE && m.side == SIDE_BUY) begin
                        stats_tbl[m.locate].buy += m.shares;
                    end else if (m.func == FN_TRADE && m.side == SIDE_SELL) begin
                        stats_tbl[m.locate].sell += m.shares;
                    end
                end
            end
            FN_SNAPSHOT: begin
                snap.symbol    = m.locate;
                snap.notional  = stats_tbl[m.locate].notional;
                snap.volume    = stats_tbl[m.locate].volume;
                snap.buy       = stats_tbl[m.locate].buy;
                snap.sell      = stats_tbl[m.locate].sell;
                snap.cancelled = stats_tbl[m.locate].cancelled;
                snap.trades    = stats_tbl[m.locate].trades;
                snap.adds      = stats_tbl[m.locate].adds;
                snap.bid       = stats_tbl[m.locate].bid;
                snap.ask       = stats_tbl[m.locate].ask;
                expected_snaps.push_back(snap);
                stats_tbl[m.locate].bid = BID_NONE;
                stats_tbl[m.locate].ask = ASK_NONE;
            end
            default: ;
        endcase
    endfunction

    function automatic t_msg make_msg(logic [FUNC_W-1:0] func, logic [LOCATE_W-1:0] locate,
                                      logic [SIDE_W-1:0] side, logic [PRICE_W-1:0] price,
                                      logic [QTY_W-1:0] shares);
        t_msg m;
        m.func   = func;
        m.locate = locate;
        m.side   = side;
        m.price  = price;
        m.shares = shares;
        return m;
    endfunction

    function automatic t_msg random_msg();
        t_msg m;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 30)      m.func = FN_ADD;
        else if (r < 42) m.func = FN_CANCEL;
        else if (r < 67) m.func = FN_TRADE;
        else if (r < 75) m.func = FN_CROSS;
        else if (r < 78) m.func = FN_NOP;
        else if (r < 79) m.func = FN_SPARE6;
        else if (r < 80) m.func = FN_SPARE7;
        else             m.func = FN_SNAPSHOT;
        // A small set of busy symbols keeps back-to-back updates to one row common.
        r = $urandom_range(0, 99);
        if (r < 60)      m.locate = hot_locs[$urandom_range(0, 7)];
        else if (r < 88) m.locate = LOCATE_W'($urandom_range(0, SYMBOLS - 1));
        else             m.locate = LOCATE_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45)      m.side = SIDE_BUY;
        else if (r < 85) m.side = SIDE_SELL;
        else             m.side = SIDE_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 5)       m.price = '0;
        else if (r < 10) m.price = '1;
        else if (r < 60) m.price = PRICE_W'($urandom_range(900000, 1100000));
        else             m.price = $urandom;
        r = $urandom_range(0, 99);
        if (r < 12)      m.shares = '0;
        else if (r < 60) m.shares = QTY_W'($urandom_range(1, 1000));
        else             m.shares = {$urandom, $urandom};
        return m;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else             return $urandom_range(4, 30);
    endfunction

    // Driver: holds an item until it is taken, then idles for a random gap.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (msg_accept) begin
                apply_message(cur_msg);
                n_sent <= n_sent + 1;
            end
            if (start && !msg_accept) begin
                // Item still waiting for the block; hold everything.
            end else if (gap_left > 0 || pending_msgs.size() == 0) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                start    <= 1'b0;
                i_func   <= FUNC_W'($urandom);
                i_locate <= LOCATE_W'($urandom);
                i_side   <= SIDE_W'($urandom);
                i_price  <= $urandom;
                i_shares <= {$urandom, $urandom};
            end else begin
                cur_msg = pending_msgs.pop_front();
                start    <= 1'b1;
                i_func   <= cur_msg.func;
                i_locate <= cur_msg.locate;
                i_side   <= cur_msg.side;
                i_price  <= cur_msg.price;
                i_shares <= cur_msg.shares;
                if (calm_left > 0) begin
                    calm_left <= calm_left - 1;
                    gap_left  <= 0;
                end else if ($urandom_range(0, 99) < 3) begin
                    calm_left <= $urandom_range(20, 80);
                    gap_left  <= 0;
                end else begin
                    gap_left <= pick_gap();
                end
            end
        end
    end

    // Monitor: every strobed snapshot is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_snap want;
        if (i_rst_n && o_snap_valid) begin
            if (expected_snaps.size() == 0) begin
                report_mismatch("unexpected snapshot, symbol", 64'(o_snap_symbol), '0);
            end else begin
                want = expected_snaps.pop_front();
                n_snaps_seen++;
                check_field("symbol", 64'(o_snap_symbol), 64'(want.symbol));
                check_field("notional", o_snap_notional, want.notional);
                check_field("volume", o_snap_volume, want.volume);
                check_field("buy", o_snap_buy, want.buy);
                check_field("sell", o_snap_sell, want.sell);
                check_field("cancelled", o_snap_cancelled, want.cancelled);
                check_field("trades", 64'(o_snap_trades), 64'(want.trades));
                check_field("adds", 64'(o_snap_adds), 64'(want.adds));
                check_field("bid", 64'(o_snap_bid), 64'(want.bid));
                check_field("ask", 64'(o_snap_ask), 64'(want.ask));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || msg_accept || o_snap_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no item or snapshot moved for %0d cycles", IDLE_LIMIT);
        $display("per_symbol_market_stats_table_tb: done, errors");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_func       = '0;
        i_locate     = '0;
        i_side       = '0;
        i_price      = '0;
        i_shares     = '0;
        n_sent       = 0;
        n_snaps_seen = 0;
        n_ignored    = 0;
        n_errors     = 0;
        gap_left     = 0;
        calm_left    = 0;
        idle_cycles  = 0;
        for (int s = 0; s < SYMBOLS; s++) begin
            stats_tbl[s]     = '0;
            stats_tbl[s].bid = BID_NONE;
            stats_tbl[s].ask = ASK_NONE;
        end
        hot_locs[0] = '0;
        hot_locs[1] = LOCATE_W'(SYMBOLS - 1);
        for (int k = 2; k < 8; k++) hot_locs[k] = LOCATE_W'($urandom_range(0, SYMBOLS - 1));

        // Directed items: reset row, extremes, every func, and the odd cases.
        pending_msgs.push_back(make_msg(FN_SNAPSHOT, 0, 0, 0, 0));
        pending_msgs.push_back(make_msg(FN_ADD, 0, SIDE_BUY, '1, 0));
        pending_msgs.push_back(make_msg(FN_ADD, 0, SIDE_SELL, '0, 0));
        pending_msgs.push_back(make_msg(FN_ADD, 0, 8'hFF, 5, 0));
        pending_msgs.push_back(make_msg(FN_CANCEL, 0, 0, 0, '1));
        pending_msgs.push_back(make_msg(FN_CANCEL, 0, 0, 0, '0));
        pending_msgs.push_back(make_msg(FN_TRADE, 0, SIDE_BUY, '1, '1));
        pending_msgs.push_back(make_msg(FN_TRADE, 0, SIDE_SELL, 3, 7));
        pending_msgs.push_back(make_msg(FN_TRADE, 0, 8'h00, 10, 2));
        pending_msgs.push_back(make_msg(FN_TRADE, 0, SIDE_BUY, 99, '0));
        pending_msgs.push_back(make_msg(FN_CROSS, 0, SIDE_BUY, 100, 5));
        pending_msgs.push_back(make_msg(FN_CROSS, 0, SIDE_SELL, 100, '0));
        pending_msgs.push_back(make_msg(FN_NOP, 0, SIDE_BUY, 7, 7));
        pending_msgs.push_back(make_msg(FN_SPARE6, 0, SIDE_BUY, 7, 7));
        pending_msgs.push_back(make_msg(FN_SPARE7, 0, SIDE_SELL, 7, 7));
        pending_msgs.push_back(make_msg(FN_SNAPSHOT, 0, 0, 0, 0));
        pending_msgs.push_back(make_msg(FN_SNAPSHOT, 0, 0, 0, 0));
        pending_msgs.push_back(make_msg(FN_ADD, LOCATE_W'(SYMBOLS - 1), SIDE_BUY, 1234, 0));
        pending_msgs.push_back(make_msg(FN_TRADE, LOCATE_W'(SYMBOLS - 1), SIDE_SELL, 1, 1));
        pending_msgs.push_back(make_msg(FN_ADD, LOCATE_W'(SYMBOLS), SIDE_BUY, 55, 0));
        pending_msgs.push_back(make_msg(FN_TRADE, LOCATE_W'(SYMBOLS), SIDE_BUY, 55, 9));
        pending_msgs.push_back(make_msg(FN_SNAPSHOT, LOCATE_W'(SYMBOLS), 0, 0, 0));
        pending_msgs.push_back(make_msg(FN_SNAPSHOT, 16'hFFFF, 0, 0, 0));
        pending_msgs.push_back(make_msg(FN_SNAPSHOT, LOCATE_W'(SYMBOLS - 1), 0, 0, 0));

        // Random items, ignored ones included.
        for (int k = 0; k < N_RANDOM; k++) pending_msgs.push_back(random_msg());
        // Close with a snapshot of every busy symbol so late updates are seen.
        for (int k = 0; k < 8; k++) pending_msgs.push_back(make_msg(FN_SNAPSHOT, hot_locs[k],
                                                                    0, 0, 0));
        n_total = pending_msgs.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_total || expected_snaps.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (expected_snaps.size() != 0) begin
            report_mismatch("snapshots never seen", 64'(expected_snaps.size()), '0);
        end
        $display("%0d items sent, %0d snapshots compared, %0d items with an unused locate",
                 n_sent, n_snaps_seen, n_ignored);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0) begin
            $display("per_symbol_market_stats_table_tb: done, clean");
        end else begin
            $display("per_symbol_market_stats_table_tb: done, errors");
        end
        $finish;
    end

endmodule
